// File: src/sla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_pkg
// Shared constants, types and arithmetic helpers of the grid advection block.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int INTERIOR_SIZE = 62;
    localparam int FRACTION_BITS = 16;
    localparam int PADDED_WIDTH  = INTERIOR_SIZE + 2;
    localparam int CELL_COUNT    = PADDED_WIDTH * PADDED_WIDTH;
    localparam int ADDR_W        = 12;
    localparam int COORD_W       = 8;
    localparam int DATA_W        = 32;
    localparam int TSTEP_W       = 24;
    localparam int DT0_W         = TSTEP_W + COORD_W;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BND_COPY   = 2'd0,
        BND_NEG_LR = 2'd1,
        BND_NEG_TB = 2'd2
    } bnd_t;

    localparam logic [0:0] CFG_TIME_STEP = 1'b0;
    localparam logic [0:0] CFG_BOUNDARY  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INT_ADDR,
        ST_INT_VEL,
        ST_INT_MUL,
        ST_INT_TRACE,
        ST_INT_S00,
        ST_INT_S01,
        ST_INT_S10,
        ST_INT_S11,
        ST_INT_MIX,
        ST_INT_WR,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_CORNER_RD,
        ST_CORNER_WR,
        ST_DONE
    } state_t;

    // Request from the sequencer to the arithmetic datapath.
    typedef struct packed {
        logic load_vel;
        logic mul_vel;
        logic trace;
        logic [1:0] samp_sel;
        logic samp_load;
        logic mix;
    } dp_ctrl_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] c,
                                                    input logic [COORD_W-1:0] r);
        logic [ADDR_W+COORD_W-1:0] a;
        begin
            a = (ADDR_W+COORD_W)'(c) + (ADDR_W+COORD_W)'(r) * (ADDR_W+COORD_W)'(PADDED_WIDTH);
            return a[ADDR_W-1:0];
        end
    endfunction

endpackage : sla_pkg
`default_nettype wire

// File: src/sla_grid_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_grid_mem
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sla_grid_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : sla_grid_mem
`default_nettype wire

// File: src/sla_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_datapath
// Backtrace and bilinear sampling arithmetic, one multiply stage per step.
// ----------------------------------------------------------------------------
module sla_datapath (
    input  wire logic                               clk,
    input  wire sla_pkg::dp_ctrl_t                  ctrl,
    input  wire logic [sla_pkg::DT0_W-1:0]          dt0,
    input  wire logic [sla_pkg::COORD_W-1:0]        col,
    input  wire logic [sla_pkg::COORD_W-1:0]        row,
    input  wire logic [sla_pkg::DATA_W-1:0]         vx,
    input  wire logic [sla_pkg::DATA_W-1:0]         vy,
    input  wire logic [sla_pkg::DATA_W-1:0]         sample,
    output logic      [sla_pkg::COORD_W-1:0]        c0,
    output logic      [sla_pkg::COORD_W-1:0]        r0,
    output logic      [sla_pkg::DATA_W-1:0]         result
);

    localparam int F   = sla_pkg::FRACTION_BITS;
    localparam int DW  = sla_pkg::DATA_W;
    localparam int PW  = sla_pkg::DT0_W + DW;
    localparam int XW  = sla_pkg::COORD_W + F + 2;
    localparam int AW  = DW + F + 3;

    logic [DW-1:0] mag_x_reg, mag_y_reg;
    logic          neg_x_reg, neg_y_reg;
    logic [PW-1:0] px_reg, py_reg;
    logic [F-1:0]  s1_reg, t1_reg;
    logic signed [DW-1:0] q_reg [3];
    logic [1:0]    sel_reg;
    logic          pend_reg;

    function automatic logic [XW-1:0] clamp_trace(input logic [sla_pkg::COORD_W-1:0] pos,
                                                  input logic [PW-1:0] p,
                                                  input logic neg);
        logic signed [PW+1:0] x;
        logic signed [PW+1:0] lo;
        logic signed [PW+1:0] hi;
        logic signed [PW+1:0] sp;
        begin
            lo = (PW+2)'(1) <<< (F-1);
            hi = ((PW+2)'(sla_pkg::INTERIOR_SIZE) <<< F) + lo;
            sp = $signed({2'b00, p >> F});
            x  = ($signed((PW+2)'(pos)) <<< F) - (neg ? -sp : sp);
            if (x < lo) x = lo;
            if (x > hi) x = hi;
            return x[XW-1:0];
        end
    endfunction

    function automatic logic signed [DW+1:0] shr_t(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        logic [AW-1:0] q;
        begin
            m = v[AW-1] ? -v : v;
            q = m >> F;
            return v[AW-1] ? -(DW+2)'(q) : (DW+2)'(q);
        end
    endfunction

    logic [XW-1:0] xt, yt;
    logic signed [DW+1:0] in0, in1, fin;
    logic signed [F+1:0] s0, s1s, t0, t1s;

    assign xt  = clamp_trace(col, px_reg, neg_x_reg);
    assign yt  = clamp_trace(row, py_reg, neg_y_reg);
    assign t1s = $signed({2'b00, t1_reg});
    assign t0  = $signed((F+2)'(1) << F) - t1s;
    assign s1s = $signed({2'b00, s1_reg});
    assign s0  = $signed((F+2)'(1) << F) - s1s;
    assign in0 = shr_t(AW'(t0 * q_reg[0]) + AW'(t1s * q_reg[1]));
    // The last neighbor is taken straight from the RAM output in the mix cycle.
    assign in1 = shr_t(AW'(t0 * q_reg[2]) + AW'(t1s * $signed(sample)));

    logic signed [DW+1:0] in0_reg, in1_reg;
    assign fin = shr_t(AW'(s0 * in0_reg) + AW'(s1s * in1_reg));

    always_ff @(posedge clk)
    begin
        if (ctrl.load_vel)
        begin
            neg_x_reg <= vx[DW-1];
            neg_y_reg <= vy[DW-1];
            mag_x_reg <= vx[DW-1] ? -vx : vx;
            mag_y_reg <= vy[DW-1] ? -vy : vy;
        end
        if (ctrl.mul_vel)
        begin
            px_reg <= PW'(dt0) * PW'(mag_x_reg);
            py_reg <= PW'(dt0) * PW'(mag_y_reg);
        end
        if (ctrl.trace)
        begin
            c0     <= xt[F +: sla_pkg::COORD_W];
            r0     <= yt[F +: sla_pkg::COORD_W];
            s1_reg <= xt[F-1:0];
            t1_reg <= yt[F-1:0];
        end
        pend_reg <= ctrl.samp_load;
        sel_reg  <= ctrl.samp_sel;
        if (pend_reg)
        begin
            q_reg[sel_reg] <= $signed(sample);
        end
        if (ctrl.mix)
        begin
            in0_reg <= in0;
            in1_reg <= in1;
        end
    end

    assign result = fin[DW-1:0];

endmodule : sla_datapath
`default_nettype wire

// File: src/sla_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sla_sequencer
// Walks interior cells, then edge cells and corners, steering memory ports.
// ----------------------------------------------------------------------------
module sla_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [1:0]                    bmode,
    input  wire logic [sla_pkg::COORD_W-1:0]   c0,
    input  wire logic [sla_pkg::COORD_W-1:0]   r0,
    input  wire logic [sla_pkg::DATA_W-1:0]    mix_result,
    input  wire logic [sla_pkg::DATA_W-1:0]    res_rdata,
    output sla_pkg::dp_ctrl_t                  ctrl,
    output logic                               active,
    output logic                               done,
    output logic [sla_pkg::COORD_W-1:0]        col,
    output logic [sla_pkg::COORD_W-1:0]        row,
    output logic [sla_pkg::ADDR_W-1:0]         vel_raddr,
    output logic [sla_pkg::ADDR_W-1:0]         src_raddr,
    output logic [sla_pkg::ADDR_W-1:0]         res_raddr,
    output logic                               res_we,
    output logic [sla_pkg::ADDR_W-1:0]         res_waddr,
    output logic [sla_pkg::DATA_W-1:0]         res_wdata
);

    localparam int N  = sla_pkg::INTERIOR_SIZE;
    localparam int CW = sla_pkg::COORD_W;
    localparam int DW = sla_pkg::DATA_W;

    sla_pkg::state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    logic [CW-1:0] k_reg, k_next;
    logic [1:0]    side_reg, side_next;
    logic [DW-1:0] first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sla_pkg::ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            k_reg     <= '0;
            side_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            side_reg  <= side_next;
        end
    end

    // Edge step: side 0 left, 1 right, 2 top, 3 bottom; k walks 1..N.
    // Corner step: side selects the corner, k counts its two reads.
    logic [CW-1:0] e_src_c, e_src_r, e_dst_c, e_dst_r;
    logic          e_neg;
    logic [CW-1:0] k_src_c, k_src_r, k_dst_c, k_dst_r;
    logic [CW-1:0] kc, nc, n1;

    assign nc = CW'(N);
    assign n1 = CW'(N + 1);

    always_comb
    begin
        kc = k_reg;
        case (side_reg)
            2'd0:
            begin
                e_src_c = CW'(1); e_src_r = kc; e_dst_c = CW'(0); e_dst_r = kc;
                e_neg   = (bmode == sla_pkg::BND_NEG_LR);
            end
            2'd1:
            begin
                e_src_c = nc; e_src_r = kc; e_dst_c = n1; e_dst_r = kc;
                e_neg   = (bmode == sla_pkg::BND_NEG_LR);
            end
            2'd2:
            begin
                e_src_c = kc; e_src_r = CW'(1); e_dst_c = kc; e_dst_r = CW'(0);
                e_neg   = (bmode == sla_pkg::BND_NEG_TB);
            end
            default:
            begin
                e_src_c = kc; e_src_r = nc; e_dst_c = kc; e_dst_r = n1;
                e_neg   = (bmode == sla_pkg::BND_NEG_TB);
            end
        endcase
        case (side_reg)
            2'd0:
            begin
                k_dst_c = CW'(0); k_dst_r = CW'(0);
                k_src_c = k_reg[0] ? CW'(0) : CW'(1);
                k_src_r = k_reg[0] ? CW'(1) : CW'(0);
            end
            2'd1:
            begin
                k_dst_c = CW'(0); k_dst_r = n1;
                k_src_c = k_reg[0] ? CW'(0) : CW'(1);
                k_src_r = k_reg[0] ? nc : n1;
            end
            2'd2:
            begin
                k_dst_c = n1; k_dst_r = CW'(0);
                k_src_c = k_reg[0] ? n1 : nc;
                k_src_r = k_reg[0] ? CW'(1) : CW'(0);
            end
            default:
            begin
                k_dst_c = n1; k_dst_r = n1;
                k_src_c = k_reg[0] ? n1 : nc;
                k_src_r = k_reg[0] ? nc : n1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        side_next  = side_reg;
        case (state_reg)
            sla_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    state_next = sla_pkg::ST_INT_ADDR;
                    col_next   = CW'(1);
                    row_next   = CW'(1);
                end
            end
            sla_pkg::ST_INT_ADDR:  state_next = sla_pkg::ST_INT_VEL;
            sla_pkg::ST_INT_VEL:   state_next = sla_pkg::ST_INT_MUL;
            sla_pkg::ST_INT_MUL:   state_next = sla_pkg::ST_INT_TRACE;
            sla_pkg::ST_INT_TRACE: state_next = sla_pkg::ST_INT_S00;
            sla_pkg::ST_INT_S00:   state_next = sla_pkg::ST_INT_S01;
            sla_pkg::ST_INT_S01:   state_next = sla_pkg::ST_INT_S10;
            sla_pkg::ST_INT_S10:   state_next = sla_pkg::ST_INT_S11;
            sla_pkg::ST_INT_S11:   state_next = sla_pkg::ST_INT_MIX;
            sla_pkg::ST_INT_MIX:   state_next = sla_pkg::ST_INT_WR;
            sla_pkg::ST_INT_WR:
            begin
                if (row_reg == nc)
                begin
                    row_next = CW'(1);
                    if (col_reg == nc)
                    begin
                        state_next = sla_pkg::ST_EDGE_RD;
                        side_next  = 2'd0;
                        k_next     = CW'(1);
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = sla_pkg::ST_INT_ADDR;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = sla_pkg::ST_INT_ADDR;
                end
            end
            sla_pkg::ST_EDGE_RD:   state_next = sla_pkg::ST_EDGE_WR;
            sla_pkg::ST_EDGE_WR:
            begin
                state_next = sla_pkg::ST_EDGE_RD;
                if (side_reg == 2'd3)
                begin
                    side_next = 2'd0;
                    if (k_reg == nc)
                    begin
                        state_next = sla_pkg::ST_CORNER_RD;
                        k_next     = CW'(0);
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    side_next = side_reg + 1'b1;
                end
            end
            sla_pkg::ST_CORNER_RD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg[0])
                begin
                    state_next = sla_pkg::ST_CORNER_WR;
                end
            end
            sla_pkg::ST_CORNER_WR:
            begin
                k_next = CW'(0);
                if (side_reg == 2'd3)
                begin
                    state_next = sla_pkg::ST_DONE;
                end
                else
                begin
                    side_next  = side_reg + 1'b1;
                    state_next = sla_pkg::ST_CORNER_RD;
                end
            end
            sla_pkg::ST_DONE:      state_next = sla_pkg::ST_IDLE;
            default:               state_next = sla_pkg::ST_IDLE;
        endcase
    end

    // The first corner operand arrives while the second is being read.
    logic signed [DW:0] csum;
    logic [DW:0]        cmag;
    logic signed [DW:0] cavg;
    always_comb
    begin
        csum = $signed({first_reg[DW-1], first_reg}) + $signed({res_rdata[DW-1], res_rdata});
        cmag = csum[DW] ? -csum : csum;
        cavg = csum[DW] ? -$signed(cmag >> 1) : $signed(cmag >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sla_pkg::ST_CORNER_RD && k_reg[0])
        begin
            first_reg <= res_rdata;
        end
    end

    always_comb
    begin
        ctrl      = '0;
        active    = (state_reg != sla_pkg::ST_IDLE);
        done      = (state_reg == sla_pkg::ST_DONE);
        col       = col_reg;
        row       = row_reg;
        vel_raddr = sla_pkg::cell_addr(col_reg, row_reg);
        src_raddr = sla_pkg::cell_addr(c0, r0);
        res_raddr = sla_pkg::cell_addr(e_src_c, e_src_r);
        res_we    = 1'b0;
        res_waddr = sla_pkg::cell_addr(col_reg, row_reg);
        res_wdata = mix_result;
        case (state_reg)
            sla_pkg::ST_INT_VEL:   ctrl.load_vel = 1'b1;
            sla_pkg::ST_INT_MUL:   ctrl.mul_vel  = 1'b1;
            sla_pkg::ST_INT_TRACE: ctrl.trace    = 1'b1;
            sla_pkg::ST_INT_S00:
            begin
                ctrl.samp_load = 1'b1;
                ctrl.samp_sel  = 2'd0;
            end
            sla_pkg::ST_INT_S01:
            begin
                ctrl.samp_load = 1'b1;
                ctrl.samp_sel  = 2'd1;
                src_raddr      = sla_pkg::cell_addr(c0, r0 + 1'b1);
            end
            sla_pkg::ST_INT_S10:
            begin
                ctrl.samp_load = 1'b1;
                ctrl.samp_sel  = 2'd2;
                src_raddr      = sla_pkg::cell_addr(c0 + 1'b1, r0);
            end
            sla_pkg::ST_INT_S11:
            begin
                // This sample is blended directly from the RAM output.
                src_raddr      = sla_pkg::cell_addr(c0 + 1'b1, r0 + 1'b1);
            end
            sla_pkg::ST_INT_MIX:
            begin
                ctrl.mix = 1'b1;
            end
            sla_pkg::ST_INT_WR:
            begin
                res_we = 1'b1;
            end
            sla_pkg::ST_EDGE_WR:
            begin
                res_we    = 1'b1;
                res_waddr = sla_pkg::cell_addr(e_dst_c, e_dst_r);
                res_wdata = e_neg ? -res_rdata : res_rdata;
            end
            sla_pkg::ST_CORNER_RD:
            begin
                res_raddr = sla_pkg::cell_addr(k_src_c, k_src_r);
            end
            sla_pkg::ST_CORNER_WR:
            begin
                res_we    = 1'b1;
                res_waddr = sla_pkg::cell_addr(k_dst_c, k_dst_r);
                res_wdata = cavg[DW-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule : sla_sequencer
`default_nettype wire

// File: src/semi_lagrangian_grid_advection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// semi_lagrangian_grid_advection
// Bilinear semi-Lagrangian advection over a padded grid held in block RAM.
// ----------------------------------------------------------------------------
// A write command gives no result. A read command returns its cell in the
// cycle right after the transfer, on a one-cycle done strobe; busy is high
// for that cycle, so no new command is taken then. A run command walks the
// interior cells one at a time (velocity read, backtrace multiply, four
// source reads through the single source RAM port, blend, write), then
// fills each edge cell with a read and a write and each corner with two
// reads and a write; busy is high throughout, up to the done strobe.
// Results cannot be held off by the receiver. The mix of a cell is
// written while its sampled neighbors are still in the pipeline, but source
// and result live in separate RAMs, so there is no read-after-write hazard
// inside a run; edge cells read result cells finished in earlier steps, and
// the edge pass interleaves read and write so each written value is settled
// before any later read.
module semi_lagrangian_grid_advection (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     command,
    input  wire logic [sla_pkg::ADDR_W-1:0]     cell_index,
    input  wire logic signed [31:0]             quantity_in,
    input  wire logic signed [31:0]             velocity_x_in,
    input  wire logic signed [31:0]             velocity_y_in,
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [sla_pkg::TSTEP_W-1:0]    cfg_data,
    output logic                                done,
    output logic                                result_kind,
    output logic [sla_pkg::ADDR_W-1:0]          cell_index_out,
    output logic signed [31:0]                  quantity_out
);

    localparam int AW = sla_pkg::ADDR_W;
    localparam int DW = sla_pkg::DATA_W;

    logic [sla_pkg::TSTEP_W-1:0] time_step_reg;
    logic [1:0]                  bmode_reg;
    logic [sla_pkg::DT0_W-1:0]   dt0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= sla_pkg::TSTEP_W'(6554);
            bmode_reg     <= sla_pkg::BND_COPY;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sla_pkg::CFG_TIME_STEP)
                time_step_reg <= cfg_data;
            else
                bmode_reg <= cfg_data[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dt0_reg <= sla_pkg::DT0_W'(time_step_reg) * sla_pkg::DT0_W'(sla_pkg::INTERIOR_SIZE);
    end

    logic xfer, in_range;
    assign xfer     = start && !busy;
    assign in_range = ({1'b0, cell_index} < (AW+1)'(sla_pkg::CELL_COUNT));

    sla_pkg::dp_ctrl_t ctrl;
    logic seq_active, seq_done;
    logic [sla_pkg::COORD_W-1:0] col, row, c0, r0;
    logic [AW-1:0] vel_raddr, src_raddr, seq_res_raddr, res_waddr, res_raddr;
    logic [DW-1:0] vx, vy, sample, mix_result, res_rdata, res_wdata;
    logic          res_we, write_cmd;

    assign write_cmd = xfer && (command == sla_pkg::CMD_WRITE) && in_range;
    assign res_raddr = seq_active ? seq_res_raddr : cell_index;

    sla_grid_mem #(.WIDTH(DW), .DEPTH(sla_pkg::CELL_COUNT), .AW(AW)) u_src (
        .clk(clk), .we(write_cmd), .waddr(cell_index), .wdata(quantity_in),
        .raddr(src_raddr), .rdata(sample));
    sla_grid_mem #(.WIDTH(DW), .DEPTH(sla_pkg::CELL_COUNT), .AW(AW)) u_vx (
        .clk(clk), .we(write_cmd), .waddr(cell_index), .wdata(velocity_x_in),
        .raddr(vel_raddr), .rdata(vx));
    sla_grid_mem #(.WIDTH(DW), .DEPTH(sla_pkg::CELL_COUNT), .AW(AW)) u_vy (
        .clk(clk), .we(write_cmd), .waddr(cell_index), .wdata(velocity_y_in),
        .raddr(vel_raddr), .rdata(vy));
    sla_grid_mem #(.WIDTH(DW), .DEPTH(sla_pkg::CELL_COUNT), .AW(AW)) u_res (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata));

    sla_datapath u_dp (
        .clk(clk), .ctrl(ctrl), .dt0(dt0_reg), .col(col), .row(row),
        .vx(vx), .vy(vy), .sample(sample), .c0(c0), .r0(r0), .result(mix_result));

    sla_sequencer u_seq (
        .clk(clk), .rst_n(rst_n), .go(xfer && (command == sla_pkg::CMD_RUN)),
        .bmode(bmode_reg), .c0(c0), .r0(r0), .mix_result(mix_result),
        .res_rdata(res_rdata), .ctrl(ctrl), .active(seq_active), .done(seq_done),
        .col(col), .row(row), .vel_raddr(vel_raddr), .src_raddr(src_raddr),
        .res_raddr(seq_res_raddr), .res_we(res_we), .res_waddr(res_waddr),
        .res_wdata(res_wdata));

    // Read path: address in the transfer cycle, data in the cycle after.
    logic          rd_pend_reg, rd_ok_reg;
    logic [AW-1:0] rd_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= xfer && (command == sla_pkg::CMD_READ);
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= cell_index;
        rd_ok_reg   <= in_range;
    end

    assign busy           = seq_active || rd_pend_reg;
    assign done           = seq_done || rd_pend_reg;
    assign result_kind    = seq_done;
    assign cell_index_out = seq_done ? '0 : rd_addr_reg;
    assign quantity_out   = (seq_done || !rd_ok_reg) ? '0 : $signed(res_rdata);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(seq_done && rd_pend_reg))
        else $error("read and run results collide");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> $past(busy))
        else $error("run finished without having been busy");
    a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && command == sla_pkg::CMD_READ) |=> (done && !result_kind))
        else $error("read result missing");
    a_no_ram_write_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !res_we)
        else $error("result RAM written during a read");
`endif

endmodule : semi_lagrangian_grid_advection
`default_nettype wire
